@@ sv/rbd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and small arithmetic helpers for the RGGB bilinear demosaic.
// No dependencies; the top level and the testbench take this package in.
package rbd_pkg;

	// Sizes of the fields that are fixed by the stream format.
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_DATA_W = 16;
	localparam int PIX_W      = 8;

	// Mask that keeps the low nibble of the middle raw byte.
	localparam logic [7:0] LOW_NIBBLE = 8'h0F;

	// Register reset values as written, before clamping.
	localparam int RST_WIDTH  = 4096;
	localparam logic [15:0] RST_HEIGHT = 16'd3072;
	localparam logic [15:0] MIN_SIZE   = 16'd4;

	// Configuration register indexes.
	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Kind of an input word.
	typedef enum logic {
		ACT_PIXELS = 1'b0,
		ACT_FLUSH  = 1'b1
	} action_t;

	// One pixel pair: the even-column pixel sits in the low byte.
	typedef struct packed {
		logic [PIX_W-1:0] odd;
		logic [PIX_W-1:0] even;
	} pair_t;

	// One window column: pairs of the row above, the centre row and the row below.
	typedef struct packed {
		pair_t t;
		pair_t m;
		pair_t b;
	} column_t;

	// Average of four pixels, rounded down.
	function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d);
		logic [PIX_W+1:0] s;
		s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
		return s[PIX_W+1:2];
	endfunction

	// Average of two pixels, rounded down.
	function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		logic [PIX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PIX_W:1];
	endfunction

endpackage

@@ sv/raw12_bayer_bilinear_demosaic.sv @@
`timescale 1ns / 1ps
// The input word releasing a result passes the stage 1 (RAM read), stage 2 (window) and stage 3
// (averages) registers and then the output register, which drives m_tvalid.
// Throughput: one word per cycle; a stall on the output halts the whole pipeline at once.
// The rate is set by the single line store RAM, read and written once per pair column.
// Results lag input by one row plus one pair; flush words drain the last row and the pair
// before it. Reset (arst_n low) clears counters and valid bits and sets the size registers
// to their reset values; payload registers and the line store are not cleared.
module raw12_bayer_bilinear_demosaic
	import rbd_pkg::*;
#(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,   // packed_pair[23:0]
	input  logic                   s_tuser,   // action
	// Output stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,   // left_red, left_green, left_blue,
	                                          // right_red, right_green, right_blue
	output logic                   m_tlast,   // frame_last
	// Configuration write port.
	input  logic                   cfg_wr_en,
	input  logic                   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

	localparam int PAIRS = MAX_WIDTH / 2;
	localparam int CW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int PW    = $clog2(PAIRS + 1);
	localparam int NW    = $clog2(PAIRS + 3);
	localparam int MAXE  = (MAX_WIDTH / 2) * 2;
	localparam int RSTE  = (RST_WIDTH < MAXE) ? RST_WIDTH : MAXE;
	localparam logic [14:0] MAXE_W = 15'(MAXE);
	localparam logic [PW-1:0] RST_PAIRS = PW'(RSTE / 2);

	// Configuration and position state.
	logic [PW-1:0]  p_q;
	logic [15:0]    h_q;
	logic [CW-1:0]  col_q;
	logic [15:0]    row_q;
	logic [CW-1:0]  op_q;
	logic [15:0]    orow_q;
	logic [NW-1:0]  pend_q;

	// Pipeline stage 1: RAM read in flight.
	logic           v_s1, flush_s1, emit_s1, even_s1, border_s1, last_s1, fwd_s1;
	pair_t          pix_s1;
	logic [CW-1:0]  addr_s1;
	logic [31:0]    fwdw_s1;

	// Pipeline stage 2: window formed.
	logic           v_s2, flush_s2, emit_s2, even_s2, border_s2, last_s2;
	column_t        ovr_s2;
	column_t        win_q [3];

	// Pipeline stage 3: interpolated values.
	logic           v_s3, emit_s3, border_s3, last_s3;
	logic [PIX_W-1:0] iv_s3 [6];
	logic [PIX_W-1:0] bd_s3 [3];

	logic           en, take;
	logic [31:0]    rd_data, rd_eff;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign take     = s_tvalid && en;

	// Clamped sizes from a configuration write.
	logic [14:0]    w_cl;
	logic [15:0]    h_cl;
	always_comb begin
		w_cl = {2'b00, cfg_wr_data[12:1], 1'b0};
		if (w_cl < 15'(MIN_SIZE)) begin
			w_cl = 15'(MIN_SIZE);
		end
		if (w_cl > MAXE_W) begin
			w_cl = MAXE_W;
		end
		h_cl = {cfg_wr_data[15:1], 1'b0};
		if (h_cl < MIN_SIZE) begin
			h_cl = MIN_SIZE;
		end
	end

	// Next positions for an accepted word.
	logic           is_flush, done, emit_n, border_n, last_n, even_n;
	logic [CW-1:0]  col_c, op_c, op_e, col_nx, op_nx;
	logic [15:0]    row_c, orow_c, orow_e, row_nx, orow_nx;
	logic [NW-1:0]  pend_c, pend_inc, pend_nx;
	logic [PW-1:0]  col_inc, op_inc;
	logic [CW-1:0]  rd_addr;

	always_comb begin
		is_flush = (action_t'(s_tuser) == ACT_FLUSH);
		done     = (row_q >= h_q);
		col_c    = done ? '0 : col_q;
		row_c    = done ? '0 : row_q;
		op_c     = done ? '0 : op_q;
		orow_c   = done ? '0 : orow_q;
		pend_c   = done ? '0 : pend_q;
		pend_inc = pend_c + NW'(1);
		if (is_flush) begin
			emit_n = done && (pend_q != '0);
			op_e   = op_q;
			orow_e = orow_q;
		end else begin
			emit_n = (pend_inc >= NW'(p_q) + NW'(2));
			op_e   = op_c;
			orow_e = orow_c;
		end
		even_n   = !orow_e[0];
		border_n = (orow_e == '0) || (orow_e >= h_q - 16'd1) || (op_e == '0)
			|| (PW'(op_e) >= p_q - PW'(1));
		last_n   = (orow_e == h_q - 16'd1) && (PW'(op_e) == p_q - PW'(1));

		// Input position.
		col_inc = PW'(col_c) + PW'(1);
		if (col_inc >= p_q) begin
			col_nx = '0;
			row_nx = row_c + 16'd1;
		end else begin
			col_nx = col_inc[CW-1:0];
			row_nx = row_c;
		end

		// Output position.
		op_inc = PW'(op_e) + PW'(1);
		if (op_inc >= p_q) begin
			op_nx   = '0;
			orow_nx = orow_e + 16'd1;
		end else begin
			op_nx   = op_inc[CW-1:0];
			orow_nx = orow_e;
		end

		if (is_flush) begin
			pend_nx = pend_q - NW'(1);
		end else if (emit_n) begin
			pend_nx = pend_inc - NW'(1);
		end else begin
			pend_nx = pend_inc;
		end

		rd_addr = is_flush ? op_q : col_c;
	end

	// Configuration registers and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q    <= RST_PAIRS;
			h_q    <= RST_HEIGHT;
			col_q  <= '0;
			row_q  <= '0;
			op_q   <= '0;
			orow_q <= '0;
			pend_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  p_q <= w_cl[PW:1];
				REG_IMAGE_HEIGHT: h_q <= h_cl;
				default:          p_q <= p_q;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			op_q   <= '0;
			orow_q <= '0;
			pend_q <= '0;
		end else if (take) begin
			// Pixel words move the input position; emitting words move the output position.
			if (!is_flush) begin
				col_q  <= col_nx;
				row_q  <= row_nx;
			end
			if (!is_flush || emit_n) begin
				pend_q <= pend_nx;
			end
			if (emit_n) begin
				op_q   <= op_nx;
				orow_q <= orow_nx;
			end else if (!is_flush) begin
				op_q   <= op_c;
				orow_q <= orow_c;
			end
		end
	end

	// Line store: each pair column holds the pairs of the two most recent rows.
	logic        wr_now;
	logic [31:0] wr_word;
	assign rd_eff  = fwd_s1 ? fwdw_s1 : rd_data;
	assign wr_now  = en && v_s1 && !flush_s1;
	assign wr_word = {rd_eff[15:0], pix_s1};

	rbd_ram #(
		.WIDTH (32),
		.DEPTH (PAIRS)
	) u_line_store (
		.clk     (clk),
		.wr_en   (wr_now),
		.wr_addr (addr_s1),
		.wr_data (wr_word),
		.rd_en   (en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Stage 1 valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
		end
	end

	// Stage 1 payload: decoded pixels and output position flags.
	always_ff @(posedge clk) begin
		if (en) begin
			flush_s1    <= is_flush;
			emit_s1     <= emit_n;
			even_s1     <= even_n;
			border_s1   <= border_n;
			last_s1     <= last_n;
			addr_s1     <= rd_addr;
			pix_s1.even <= s_tdata[23:16];
			pix_s1.odd  <= {s_tdata[11:8] & LOW_NIBBLE[3:0], s_tdata[7:4]};
			fwd_s1      <= wr_now && (addr_s1 == rd_addr);
			fwdw_s1     <= wr_word;
		end
	end

	// Stage 2 valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	// Stage 2 payload and the three-column window, which moves on pixel words only.
	always_ff @(posedge clk) begin
		if (en) begin
			flush_s2  <= flush_s1;
			emit_s2   <= emit_s1;
			even_s2   <= even_s1;
			border_s2 <= border_s1;
			last_s2   <= last_s1;
			ovr_s2.t  <= rd_eff[31:16];
			ovr_s2.m  <= even_s1 ? rd_eff[31:16] : rd_eff[15:0];
			ovr_s2.b  <= rd_eff[15:0];
			if (v_s1 && !flush_s1) begin
				win_q[0]   <= win_q[1];
				win_q[1]   <= win_q[2];
				win_q[2].t <= rd_eff[31:16];
				win_q[2].m <= rd_eff[15:0];
				win_q[2].b <= pix_s1;
			end
		end
	end

	// Bilinear averages for the centre pair of the window.
	column_t          cl, cc, cr;
	logic [PIX_W-1:0] iv [6];
	logic [PIX_W-1:0] bd [3];
	always_comb begin
		cl = win_q[0];
		cc = flush_s2 ? ovr_s2 : win_q[1];
		cr = win_q[2];
		if (even_s2) begin
			iv[0] = cc.m.even;
			iv[1] = avg4(cc.t.even, cc.b.even, cl.m.odd, cc.m.odd);
			iv[2] = avg4(cl.t.odd, cc.t.odd, cl.b.odd, cc.b.odd);
			iv[3] = avg2(cc.m.even, cr.m.even);
			iv[4] = cc.m.odd;
			iv[5] = avg2(cc.t.odd, cc.b.odd);
			bd[0] = cc.m.even;
			bd[1] = cc.m.odd;
			bd[2] = cc.b.odd;
		end else begin
			iv[0] = avg2(cc.t.even, cc.b.even);
			iv[1] = cc.m.even;
			iv[2] = avg2(cl.m.odd, cc.m.odd);
			iv[3] = avg4(cc.t.even, cr.t.even, cc.b.even, cr.b.even);
			iv[4] = avg4(cc.t.odd, cc.b.odd, cc.m.even, cr.m.even);
			iv[5] = cc.m.odd;
			bd[0] = cc.t.even;
			bd[1] = cc.m.even;
			bd[2] = cc.m.odd;
		end
	end

	// Stage 3 valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	// Stage 3 payload.
	always_ff @(posedge clk) begin
		if (en) begin
			emit_s3   <= emit_s2;
			border_s3 <= border_s2;
			last_s3   <= last_s2;
			iv_s3     <= iv;
			bd_s3     <= bd;
		end
	end

	// Output register: border pairs repeat one RGB triple for both pixels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v_s3 && emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tlast <= last_s3;
			if (border_s3) begin
				m_tdata <= {bd_s3[2], bd_s3[1], bd_s3[0], bd_s3[2], bd_s3[1], bd_s3[0]};
			end else begin
				m_tdata <= {iv_s3[5], iv_s3[4], iv_s3[3], iv_s3[2], iv_s3[1], iv_s3[0]};
			end
		end
	end

`ifndef SYNTH
	// Pending pairs never exceed one row plus one pair.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		NW'(p_q) + NW'(1) >= pend_q)
		else $error("pending count exceeds the row lag");

	// The output position never runs ahead of the input row.
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		orow_q <= row_q)
		else $error("output row ahead of input row");

	// The input column stays inside the active line.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(col_q) < p_q)
		else $error("input column beyond line width");

	// Results drained by flush words are always border pairs.
	a_flush_border: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && flush_s1 && emit_s1) |-> border_s1)
		else $error("flush result is not a border pair");
`endif

endmodule

@@ sv/rbd_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents. No dependencies.
module rbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read share the clock edge.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for raw12_bayer_bilinear_demosaic: random frames and flushes
// are driven in, and every RGB pair out is checked against a built-in demosaic predictor.
// Depends on rbd_pkg and the RTL of the block only.
module tb_top
	import rbd_pkg::*;
;

	localparam int LINE_MAX  = 4096;
	localparam int CYCLE_CAP = 600000;

	// One input word as queued for the driver.
	typedef struct {
		action_t     act;
		logic [23:0] bytes;
	} raw_word_t;

	// One expected output word.
	typedef struct {
		logic [47:0] rgb;
		logic        last;
	} rgb_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

	raw12_bayer_bilinear_demosaic dut (.*);

	// Clock: 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	raw_word_t raw_q[$];
	rgb_word_t rgb_q[$];
	raw_word_t cur_word;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        errors = 0;
	int        cycles = 0;

	// Predictor state: three line slots, registers, positions and pending count.
	logic [7:0] line_mem [0:3*LINE_MAX-1];
	int width_reg = RST_WIDTH;
	int height_reg = RST_HEIGHT;
	int in_col, in_row, out_col, out_row, pend_cnt;

	function automatic int eff_w();
		int w;
		w = width_reg & ~1;
		if (w < 4) w = 4;
		if (w > LINE_MAX) w = LINE_MAX;
		return w;
	endfunction

	function automatic int eff_h();
		int h;
		h = height_reg & 'hFFFE;
		if (h < 4) h = 4;
		return h;
	endfunction

	function automatic int pix(int row, int col);
		if (col >= LINE_MAX) return 0;
		return line_mem[(row % 3) * LINE_MAX + col];
	endfunction

	task automatic restart_frame();
		in_col = 0; in_row = 0; out_col = 0; out_row = 0; pend_cnt = 0;
	endtask

	// Work out the RGB of the next pair due out and queue it.
	task automatic emit_pair();
		int h, p, r, q, c0, c1;
		int v[6];
		rgb_word_t e;
		h = eff_h(); p = eff_w() >> 1;
		r = out_row; q = out_col; c0 = q * 2; c1 = c0 + 1;
		if (r == 0 || r >= h - 1 || q == 0 || q >= p - 1) begin
			if (r % 2 == 0) begin
				v[0] = pix(r, c0); v[1] = pix(r, c1); v[2] = pix(r + 1, c1);
			end else begin
				v[0] = pix(r - 1, c0); v[1] = pix(r, c0); v[2] = pix(r, c1);
			end
			v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
		end else if (r % 2 == 0) begin
			v[0] = pix(r, c0);
			v[1] = (pix(r-1, c0) + pix(r+1, c0) + pix(r, c0-1) + pix(r, c1)) >> 2;
			v[2] = (pix(r-1, c0-1) + pix(r-1, c1) + pix(r+1, c0-1) + pix(r+1, c1)) >> 2;
			v[3] = (pix(r, c0) + pix(r, c1+1)) >> 1;
			v[4] = pix(r, c1);
			v[5] = (pix(r-1, c1) + pix(r+1, c1)) >> 1;
		end else begin
			v[0] = (pix(r-1, c0) + pix(r+1, c0)) >> 1;
			v[1] = pix(r, c0);
			v[2] = (pix(r, c0-1) + pix(r, c1)) >> 1;
			v[3] = (pix(r-1, c0) + pix(r-1, c1+1) + pix(r+1, c0) + pix(r+1, c1+1)) >> 2;
			v[4] = (pix(r-1, c1) + pix(r+1, c1) + pix(r, c0) + pix(r, c1+1)) >> 2;
			v[5] = pix(r, c1);
		end
		for (int k = 0; k < 6; k++) e.rgb[k*8 +: 8] = v[k][7:0];
		e.last = (r == h - 1 && q == p - 1);
		rgb_q.push_back(e);
		out_col++;
		if (out_col >= p) begin
			out_col = 0;
			out_row++;
		end
		pend_cnt--;
	endtask

	// Advance the predictor by one accepted word.
	task automatic predict_word(raw_word_t w);
		int h, p, base, c;
		h = eff_h(); p = eff_w() >> 1;
		if (w.act == ACT_FLUSH) begin
			if (in_row >= h && pend_cnt > 0) emit_pair();
			return;
		end
		if (in_row >= h) restart_frame();
		base = (in_row % 3) * LINE_MAX;
		c = in_col * 2;
		if (c + 1 < LINE_MAX) begin
			line_mem[base + c] = w.bytes[23:16];
			line_mem[base + c + 1] = {w.bytes[11:8] & LOW_NIBBLE[3:0], w.bytes[7:4]};
		end
		in_col++;
		if (in_col >= p) begin
			in_col = 0;
			in_row++;
		end
		pend_cnt++;
		if (pend_cnt >= p + 2) emit_pair();
	endtask

	// Driver: offers the next queued word, idling at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) predict_word(cur_word);
			if (!s_tvalid || s_tready) begin
				if (raw_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_word = raw_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur_word.bytes;
					s_tuser <= cur_word.act;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver stalls and result checking.
	always @(posedge clk) begin
		rgb_word_t e;
		if (arst_n) begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				if (rgb_q.size() == 0) begin
					$display("%0t: unexpected word rgb=%h last=%b", $time, m_tdata, m_tlast);
					errors++;
				end else begin
					e = rgb_q.pop_front();
					for (int k = 0; k < 6; k++)
						if (m_tdata[k*8 +: 8] !== e.rgb[k*8 +: 8]) begin
							$display("%0t: colour %0d expected %h actual %h", $time, k,
								e.rgb[k*8 +: 8], m_tdata[k*8 +: 8]);
							errors++;
						end
					if (m_tlast !== e.last) begin
						$display("%0t: tlast expected %b actual %b", $time, e.last, m_tlast);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("[raw12_bayer_bilinear_demosaic] ERROR");
			$finish;
		end
	end

	// Hold off until every queued word is taken and every result has come.
	// The check sits on the falling edge, where the driver's updates have settled.
	task automatic wait_idle();
		while (raw_q.size() > 0 || s_tvalid || rgb_q.size() > 0) @(negedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val;
		if (idx == REG_IMAGE_WIDTH) width_reg = val & 16'h1FFF;
		else height_reg = val;
		restart_frame();
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_word(action_t a, logic [23:0] b);
		raw_word_t w;
		w.act = a;
		w.bytes = b;
		raw_q.push_back(w);
	endtask

	function automatic logic [23:0] rand_bytes();
		case ($urandom_range(0, 9))
			0: return 24'hFFFFFF;
			1: return 24'h000000;
			default: return 24'($urandom);
		endcase
	endfunction

	// One frame with random content; returns the number of pixel words queued.
	task automatic queue_frame(input int rows, output int n);
		int p;
		p = eff_w() >> 1;
		n = 0;
		for (int i = 0; i < p * rows; i++) begin
			if ($urandom_range(0, 19) == 0) push_word(ACT_FLUSH, rand_bytes());
			push_word(ACT_PIXELS, rand_bytes());
			n++;
		end
		// Usually drain the tail, now and then leave it to be dropped by the next frame.
		if (rows == eff_h() && $urandom_range(0, 9) != 0)
			for (int i = 0; i < p + 1 + $urandom_range(0, 2); i++)
				push_word(ACT_FLUSH, rand_bytes());
	endtask

	initial begin
		int n, sent;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		restart_frame();
		@(posedge clk);

		// Directed: smallest frame, extreme pixel values, early and late flushes.
		write_reg(REG_IMAGE_WIDTH, 16'd4);
		write_reg(REG_IMAGE_HEIGHT, 16'd4);
		push_word(ACT_FLUSH, 24'h000000);
		push_word(ACT_PIXELS, 24'hFFFFFF);
		push_word(ACT_PIXELS, 24'h000000);
		push_word(ACT_PIXELS, 24'hF0F0F0);
		push_word(ACT_PIXELS, 24'h0F0F0F);
		push_word(ACT_FLUSH, 24'hFFFFFF);
		push_word(ACT_PIXELS, 24'hAAAAAA);
		push_word(ACT_PIXELS, 24'h555555);
		push_word(ACT_PIXELS, 24'hFFFFFF);
		push_word(ACT_PIXELS, 24'h000000);
		for (int i = 0; i < 5; i++) push_word(ACT_FLUSH, 24'h000000);
		// A new frame right after a complete one, with no flush between.
		for (int i = 0; i < 8; i++) push_word(ACT_PIXELS, rand_bytes());
		for (int i = 0; i < 4; i++) push_word(ACT_PIXELS, rand_bytes());
		wait_idle();

		// Odd and out of range sizes that clamp to the minimum.
		write_reg(REG_IMAGE_WIDTH, 16'd0);
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		queue_frame(eff_h(), n);
		wait_idle();

		// Random frames through the four idling phases.
		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 69 : (ph == 3) ? 12 : 0;
			recv_stall_pct = (ph == 2) ? 69 : (ph == 3) ? 12 : 0;
			while (sent < 200 * (ph + 1)) begin
				write_reg(REG_IMAGE_WIDTH, 16'($urandom_range(4, 17)));
				write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(4, 9)));
				for (int f = $urandom_range(1, 3); f > 0; f--) begin
					queue_frame(eff_h(), n);
					sent += n;
				end
				wait_idle();
			end
		end

		// Widest line, written above the range: part of a first row, dropped by the
		// register writes that follow.
		send_idle_pct = 12;
		recv_stall_pct = 12;
		write_reg(REG_IMAGE_WIDTH, 16'h1FFF);
		write_reg(REG_IMAGE_HEIGHT, 16'd4);
		for (int i = 0; i < 40; i++) push_word(ACT_PIXELS, rand_bytes());
		wait_idle();

		// Tallest frame: only its first rows, then a register write drops the rest.
		write_reg(REG_IMAGE_WIDTH, 16'd4);
		write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
		queue_frame(20, n);
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, 16'd6);
		write_reg(REG_IMAGE_WIDTH, 16'd8);
		queue_frame(eff_h(), n);
		wait_idle();

		if (errors == 0 && rgb_q.size() == 0) begin
			$display("[raw12_bayer_bilinear_demosaic] OK");
		end else begin
			$display("[raw12_bayer_bilinear_demosaic] ERROR");
		end
		$finish;
	end

endmodule
